// ----- src/websocket_frame_deframer_top_defines.svh -----
// Assertion macros shared by the checker of the frame deframer.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WFD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/wfd_pkg.sv -----
// Package of the frame deframer: constants, parse phases, item records.
// Used by every module of the block; depends on nothing.
`default_nettype none
package wfd_pkg;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [2:0] KEY_BYTES   = 3'd4;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int TDATA_W = 120;

	typedef enum logic [2:0] {
		PH_BYTE0   = 3'd0,
		PH_BYTE1   = 3'd1,
		PH_EXT     = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// Classified item passed from the parser to the unmasking stage.
	typedef struct packed {
		logic        kind;
		logic        last;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] plen;
		logic [3:0]  hlen;
		logic [31:0] key;
		logic [7:0]  data;
		logic [1:0]  key_sel;
	} wfd_item_t;

	// Layout of the output tdata, lowest field last.
	typedef struct packed {
		logic [2:0]  pad;
		logic [7:0]  payload_byte;
		logic [31:0] masking_key;
		logic [3:0]  header_length;
		logic [63:0] payload_length;
		logic        masked_frame;
		logic [3:0]  frame_opcode;
		logic [2:0]  reserved_bits;
		logic        final_fragment;
	} wfd_tdata_t;

endpackage
`default_nettype wire

// ----- src/websocket_frame_deframer_top.sv -----
// A result is registered in the queue and then in the output register of the unmasking
// stage before it is offered on the output stream.
// Throughput: one stream byte per cycle while the four-entry queue has room; the queue and
// the output register keep input accepts going while a result waits to be taken.
// Reset (arst_n low, asynchronous) returns the parser to the first header byte and
// empties the queue.
// Top level of the frame deframer: parser, queue and unmasking stage.
// Depends on wfd_pkg, wfd_parser, wfd_queue and wfd_unmask.
`default_nettype none
module websocket_frame_deframer_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [7:0]                   s_tdata,  // stream_byte
	output logic                         m_tvalid,
	input  wire                          m_tready,
	// final_fragment, reserved_bits, frame_opcode, masked_frame, payload_length,
	// header_length, masking_key, payload_byte, zero padding
	output logic [wfd_pkg::TDATA_W-1:0]  m_tdata,
	output logic                         m_tuser,  // item_kind
	output logic                         m_tlast   // last_of_frame
);
	import wfd_pkg::*;

	logic       accept;
	logic       push;
	wfd_item_t  push_item;
	logic       q_valid, q_ready;
	wfd_item_t  q_item;
	wfd_tdata_t out_data;

	assign accept = s_tvalid && s_tready;

	wfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_tdata),
		.push      (push),
		.push_item (push_item)
	);

	wfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_ready  (s_tready),
		.in_item   (push_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	wfd_unmask u_unmask (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_item   (q_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_data),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

	assign m_tdata = out_data;

endmodule
`default_nettype wire

// ----- src/wfd_parser.sv -----
// Front end of the frame deframer: header parser and payload classifier.
// Depends on wfd_pkg; pushes one item record per result into the queue.
`default_nettype none
module wfd_parser (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               accept,
	input  wire  [7:0]        in_byte,
	output logic              push,
	output wfd_pkg::wfd_item_t push_item
);
	import wfd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [7:0]  fhb_q, fhb_n;
	logic        mask_q, mask_n;
	logic [6:0]  code_q, code_n;
	logic [63:0] acc_q, acc_n;
	logic [31:0] key_q, key_n;
	logic [63:0] rem_q, rem_n;
	logic [1:0]  kp_q, kp_n;
	logic        after_len, finish, emit, last, kind;
	logic [3:0]  need;
	logic [3:0]  hlen;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BYTE0;
			idx_q   <= '0;
			fhb_q   <= '0;
			mask_q  <= 1'b0;
			code_q  <= '0;
			acc_q   <= '0;
			key_q   <= '0;
			rem_q   <= '0;
			kp_q    <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			fhb_q   <= fhb_n;
			mask_q  <= mask_n;
			code_q  <= code_n;
			acc_q   <= acc_n;
			key_q   <= key_n;
			rem_q   <= rem_n;
			kp_q    <= kp_n;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		fhb_n     = fhb_q;
		mask_n    = mask_q;
		code_n    = code_q;
		acc_n     = acc_q;
		key_n     = key_q;
		rem_n     = rem_q;
		kp_n      = kp_q;
		after_len = 1'b0;
		finish    = 1'b0;
		emit      = 1'b0;
		last      = 1'b0;
		kind      = KIND_HEADER;
		need      = (code_q == LEN_CODE_16) ? 4'd2 : 4'd8;
		case (phase_q)
			PH_BYTE1: begin
				mask_n = in_byte[7];
				code_n = in_byte[6:0];
				key_n  = '0;
				idx_n  = '0;
				if (in_byte[6:0] >= LEN_CODE_16) begin
					acc_n   = '0;
					phase_n = PH_EXT;
				end else begin
					acc_n     = {57'd0, in_byte[6:0]};
					after_len = 1'b1;
				end
			end
			PH_EXT: begin
				acc_n = {acc_q[55:0], in_byte};
				if ({1'b0, idx_q} + 4'd1 >= need) begin
					after_len = 1'b1;
				end else begin
					idx_n = idx_q + 3'd1;
				end
			end
			PH_KEY: begin
				key_n = {key_q[23:0], in_byte};
				if (idx_q >= KEY_BYTES - 3'd1) begin
					finish = 1'b1;
				end else begin
					idx_n = idx_q + 3'd1;
				end
			end
			PH_PAYLOAD: begin
				kp_n  = kp_q + 2'd1;
				rem_n = rem_q - 64'd1;
				last  = (rem_n == 64'd0);
				emit  = 1'b1;
				kind  = KIND_PAYLOAD;
				if (last) begin
					phase_n = PH_BYTE0;
				end
			end
			default: begin
				fhb_n   = in_byte;
				phase_n = PH_BYTE1;
			end
		endcase
		if (after_len) begin
			idx_n = '0;
			if (mask_n) begin
				phase_n = PH_KEY;
			end else begin
				finish = 1'b1;
			end
		end
		if (finish) begin
			rem_n   = acc_n;
			kp_n    = '0;
			idx_n   = '0;
			emit    = 1'b1;
			kind    = KIND_HEADER;
			last    = (acc_n == 64'd0);
			phase_n = last ? PH_BYTE0 : PH_PAYLOAD;
		end
		hlen = 4'd2;
		if (code_n == LEN_CODE_16) begin
			hlen = hlen + 4'd2;
		end else if (code_n == LEN_CODE_64) begin
			hlen = hlen + 4'd8;
		end
		if (mask_n) begin
			hlen = hlen + 4'(KEY_BYTES);
		end
	end

	assign push = accept && emit;

	always_comb begin
		push_item.kind    = kind;
		push_item.last    = last;
		push_item.fin     = fhb_n[7];
		push_item.rsv     = fhb_n[6:4];
		push_item.opcode  = fhb_n[3:0];
		push_item.masked  = mask_n;
		push_item.plen    = acc_n;
		push_item.hlen    = hlen;
		push_item.key     = key_n;
		push_item.data    = in_byte;
		push_item.key_sel = kp_q;
	end

endmodule
`default_nettype wire

// ----- src/wfd_queue.sv -----
// Short queue of item records between the parser and the unmasking stage.
// Depends on wfd_pkg for the record type and its depth.
`default_nettype none
module wfd_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wfd_pkg::wfd_item_t in_item,
	output logic               out_valid,
	input  wire                out_ready,
	output wfd_pkg::wfd_item_t out_item
);
	import wfd_pkg::*;

	wfd_item_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push, pop;

	assign in_ready  = (count_q != QCNT_W'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/wfd_unmask.sv -----
// Back end of the frame deframer: applies the key byte and holds the result.
// Depends on wfd_pkg; drives the output stream from its own register.
`default_nettype none
module wfd_unmask (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wfd_pkg::wfd_item_t in_item,
	output logic               out_valid,
	input  wire                out_ready,
	output wfd_pkg::wfd_tdata_t out_data,
	output logic               out_kind,
	output logic               out_last
);
	import wfd_pkg::*;

	logic       valid_q;
	wfd_tdata_t data_q;
	logic       kind_q, last_q;
	logic       load;
	logic [7:0] key_byte;
	wfd_tdata_t data_n;

	assign in_ready = !valid_q || out_ready;
	assign load     = in_valid && in_ready;
	assign key_byte = 8'(in_item.key >> {~in_item.key_sel, 3'b000});

	always_comb begin
		data_n.pad            = '0;
		data_n.payload_byte   = (in_item.kind == KIND_PAYLOAD) ?
			(in_item.data ^ key_byte) : 8'd0;
		data_n.masking_key    = in_item.key;
		data_n.header_length  = in_item.hlen;
		data_n.payload_length = in_item.plen;
		data_n.masked_frame   = in_item.masked;
		data_n.frame_opcode   = in_item.opcode;
		data_n.reserved_bits  = in_item.rsv;
		data_n.final_fragment = in_item.fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_n;
			kind_q <= in_item.kind;
			last_q <= in_item.last;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

// ----- src/wfd_checker.sv -----
// Port-level checker of the frame deframer, bound to the top level.
// Depends on wfd_pkg and the assertion macros header.
`default_nettype none
`include "websocket_frame_deframer_top_defines.svh"
module wfd_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         s_tvalid,
	input wire                         s_tready,
	input wire [7:0]                   s_tdata,
	input wire                         m_tvalid,
	input wire                         m_tready,
	input wire [wfd_pkg::TDATA_W-1:0]  m_tdata,
	input wire                         m_tuser,
	input wire                         m_tlast
);
	import wfd_pkg::*;

	wfd_tdata_t d;
	logic       hdr;

	assign d   = m_tdata;
	assign hdr = m_tvalid && (m_tuser == KIND_HEADER);

	`WFD_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
	`WFD_ASSERT_SAME(a_hdr_byte_zero, hdr, d.payload_byte == 8'd0, "header result carries data")
	`WFD_ASSERT_SAME(a_hlen_range, m_tvalid, d.header_length >= 4'd2 && d.header_length <= 4'd14,
		"header length out of range")
	`WFD_ASSERT_SAME(a_unmasked_key, m_tvalid && !d.masked_frame, d.masking_key == 32'd0,
		"key present on unmasked frame")
	`WFD_ASSERT_SAME(a_empty_last, hdr && d.payload_length == 64'd0, m_tlast,
		"empty frame not closed on its header")

endmodule

bind websocket_frame_deframer_top wfd_checker u_wfd_checker (.*);
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the WebSocket frame deframer: drives a byte stream, predicts the
// header and unmasked payload items of random frames in its own model, checks each field.
// Depends on wfd_pkg and websocket_frame_deframer_top.
module tb_top;
	import wfd_pkg::*;

	localparam int N_BYTES = 1550;
	localparam int MAX_SHOWN = 50;

	typedef struct packed {
		logic       kind;
		logic       last;
		wfd_tdata_t fields;
	} frame_item_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        typed;
		logic        kind;
		logic        last;
		logic        fin;
		logic [2:0]  rsv;
		logic [3:0]  opcode;
		logic        masked;
		logic [63:0] plen;
		logic [3:0]  hlen;
		logic [31:0] key;
		logic [7:0]  data;
	} stim_row_t;

	// Empty unmasked frame with every header bit set, a short frame with a 16-bit length,
	// and a masked frame with a 64-bit length.
	stim_row_t directed_rows [0:24] = '{
		{8'hFF, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b1, KIND_HEADER, 1'b1, 1'b1, 3'd7, 4'hF, 1'b0, 64'd0, 4'd2, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h7E, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h02, 1'b1, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd2, 4'd4, 32'h0, 8'h00},
		{8'h00, 1'b1, KIND_PAYLOAD, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd2, 4'd4, 32'h0, 8'h00},
		{8'hFF, 1'b1, KIND_PAYLOAD, 1'b1, 1'b0, 3'd0, 4'h0, 1'b0, 64'd2, 4'd4, 32'h0, 8'hFF},
		{8'h82, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'hFF, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h00, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h03, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h01, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h02, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h04, 1'b0, KIND_HEADER, 1'b0, 1'b0, 3'd0, 4'h0, 1'b0, 64'd0, 4'd0, 32'h0, 8'h00},
		{8'h08, 1'b1, KIND_HEADER, 1'b0, 1'b1, 3'd0, 4'h2, 1'b1, 64'd3, 4'd14,
			32'h01020408, 8'h00},
		{8'hDE, 1'b1, KIND_PAYLOAD, 1'b0, 1'b1, 3'd0, 4'h2, 1'b1, 64'd3, 4'd14,
			32'h01020408, 8'hDF},
		{8'hAD, 1'b1, KIND_PAYLOAD, 1'b0, 1'b1, 3'd0, 4'h2, 1'b1, 64'd3, 4'd14,
			32'h01020408, 8'hAF},
		{8'hBE, 1'b1, KIND_PAYLOAD, 1'b1, 1'b1, 3'd0, 4'h2, 1'b1, 64'd3, 4'd14,
			32'h01020408, 8'hBA}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'h00;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic                m_tuser;
	logic                m_tlast;

	int          errors = 0;
	int          bytes_sent = 0;
	bit          quiet = 1'b0;
	int unsigned ready_left = 0;
	frame_item_t frame_items_due [$];

	phase_t      ph = PH_BYTE0;
	logic [2:0]  fidx = '0;
	logic [7:0]  hdr0 = '0;
	logic        mflag = 1'b0;
	logic [6:0]  lcode = '0;
	logic [63:0] plen_acc = '0;
	logic [31:0] key_acc = '0;
	logic [63:0] remaining = '0;
	logic [1:0]  kpos = '0;

	websocket_frame_deframer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic frame_item_t frame_result(input logic kind, input logic [7:0] pb,
			input logic last);
		frame_item_t r;
		logic [3:0]  hl;
		hl = 4'd2;
		if (lcode == LEN_CODE_16)
			hl = hl + 4'd2;
		else if (lcode == LEN_CODE_64)
			hl = hl + 4'd8;
		if (mflag)
			hl = hl + 4'(KEY_BYTES);
		r.kind = kind;
		r.last = last;
		r.fields.pad = '0;
		r.fields.final_fragment = hdr0[7];
		r.fields.reserved_bits = hdr0[6:4];
		r.fields.frame_opcode = hdr0[3:0];
		r.fields.masked_frame = mflag;
		r.fields.payload_length = plen_acc;
		r.fields.header_length = hl;
		r.fields.masking_key = key_acc;
		r.fields.payload_byte = pb;
		return r;
	endfunction

	task automatic header_done(output bit got, output frame_item_t r);
		remaining = plen_acc;
		kpos = '0;
		fidx = '0;
		ph = (plen_acc == 64'd0) ? PH_BYTE0 : PH_PAYLOAD;
		got = 1'b1;
		r = frame_result(KIND_HEADER, 8'h00, plen_acc == 64'd0);
	endtask

	task automatic length_done(output bit got, output frame_item_t r);
		fidx = '0;
		got = 1'b0;
		r = '0;
		if (mflag)
			ph = PH_KEY;
		else
			header_done(got, r);
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit got, output frame_item_t r);
		logic [7:0] kb;
		int         need;
		got = 1'b0;
		r = '0;
		case (ph)
			PH_BYTE1: begin
				mflag = b[7];
				lcode = b[6:0];
				key_acc = '0;
				fidx = '0;
				if (lcode >= LEN_CODE_16) begin
					plen_acc = '0;
					ph = PH_EXT;
				end else begin
					plen_acc = {57'd0, lcode};
					length_done(got, r);
				end
			end
			PH_EXT: begin
				need = (lcode == LEN_CODE_16) ? 2 : 8;
				plen_acc = {plen_acc[55:0], b};
				if (int'(fidx) + 1 >= need)
					length_done(got, r);
				else
					fidx = fidx + 3'd1;
			end
			PH_KEY: begin
				key_acc = {key_acc[23:0], b};
				if (fidx >= KEY_BYTES - 3'd1)
					header_done(got, r);
				else
					fidx = fidx + 3'd1;
			end
			PH_PAYLOAD: begin
				kb = key_acc[8 * (3 - int'(kpos)) +: 8];
				kpos = kpos + 2'd1;
				remaining = remaining - 64'd1;
				if (remaining == 64'd0)
					ph = PH_BYTE0;
				got = 1'b1;
				r = frame_result(KIND_PAYLOAD, b ^ kb, remaining == 64'd0);
			end
			default: begin
				hdr0 = b;
				ph = PH_BYTE1;
			end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
			input frame_item_t typed_item = '0);
		int unsigned gap;
		bit          got;
		frame_item_t r;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		deframe_byte(b, got, r);
		if (typed)
			frame_items_due.push_back(typed_item);
		else if (got)
			frame_items_due.push_back(r);
		bytes_sent++;
	endtask

	task automatic push_frame(input logic [7:0] b0, input bit masked, input logic [6:0] code,
			input logic [63:0] ext, input int unsigned n_payload);
		logic [31:0] key;
		key = $urandom();
		push_byte(b0);
		push_byte({masked, code});
		if (code == LEN_CODE_16) begin
			for (int i = 1; i >= 0; i--)
				push_byte(ext[8 * i +: 8]);
		end else if (code == LEN_CODE_64) begin
			for (int i = 7; i >= 0; i--)
				push_byte(ext[8 * i +: 8]);
		end
		if (masked) begin
			for (int i = 3; i >= 0; i--)
				push_byte(key[8 * i +: 8]);
		end
		repeat (n_payload) push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		if (errors <= MAX_SHOWN)
			$display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		int unsigned stall;
		if (ready_left != 0) begin
			ready_left--;
		end else begin
			stall = pick_gap();
			if (stall == 0) begin
				m_tready <= 1'b1;
				ready_left = $urandom_range(0, 7);
			end else begin
				m_tready <= 1'b0;
				ready_left = stall - 1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		frame_item_t want;
		wfd_tdata_t  got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (frame_items_due.size() == 0) begin
				report_mismatch("unexpected result item", m_tdata[63:0], 64'd0);
			end else begin
				want = frame_items_due.pop_front();
				check_field("item_kind", 64'(m_tuser), 64'(want.kind));
				check_field("last_of_frame", 64'(m_tlast), 64'(want.last));
				check_field("final_fragment", 64'(got.final_fragment),
					64'(want.fields.final_fragment));
				check_field("reserved_bits", 64'(got.reserved_bits),
					64'(want.fields.reserved_bits));
				check_field("frame_opcode", 64'(got.frame_opcode),
					64'(want.fields.frame_opcode));
				check_field("masked_frame", 64'(got.masked_frame),
					64'(want.fields.masked_frame));
				check_field("payload_length", got.payload_length,
					want.fields.payload_length);
				check_field("header_length", 64'(got.header_length),
					64'(want.fields.header_length));
				check_field("masking_key", 64'(got.masking_key),
					64'(want.fields.masking_key));
				check_field("payload_byte", 64'(got.payload_byte),
					64'(want.fields.payload_byte));
				check_field("tdata padding", 64'(got.pad), 64'(want.fields.pad));
			end
		end
	end

	initial begin
		stim_row_t   row;
		frame_item_t typed_item;
		int unsigned pick;
		int unsigned len;
		bit          masked;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			typed_item.kind = row.kind;
			typed_item.last = row.last;
			typed_item.fields.pad = '0;
			typed_item.fields.final_fragment = row.fin;
			typed_item.fields.reserved_bits = row.rsv;
			typed_item.fields.frame_opcode = row.opcode;
			typed_item.fields.masked_frame = row.masked;
			typed_item.fields.payload_length = row.plen;
			typed_item.fields.header_length = row.hlen;
			typed_item.fields.masking_key = row.key;
			typed_item.fields.payload_byte = row.data;
			push_byte(row.b, row.typed, typed_item);
		end

		// Well-formed frames with random headers, keys and payloads; some run without gaps.
		while (bytes_sent < N_BYTES) begin
			quiet = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 99);
			masked = ($urandom_range(0, 9) < 6);
			if (pick < 70) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125)
					: $urandom_range(0, 12);
				push_frame(8'($urandom_range(0, 255)), masked, 7'(len), 64'd0, len);
			end else begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300)
					: $urandom_range(0, 40);
				push_frame(8'($urandom_range(0, 255)), masked,
					(pick < 85) ? LEN_CODE_16 : LEN_CODE_64, 64'(len), len);
			end
		end

		// The largest length never completes, so it can only close the run.
		quiet = 1'b0;
		push_frame(8'($urandom_range(0, 255)), 1'b1, LEN_CODE_64, '1, 6);
		s_tvalid <= 1'b0;

		while (frame_items_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
